### rtl/ncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// ncc_pkg: shared types and constants for the nearest centroid classifier
// Field widths, register codes, request codes and the pipeline tag.
//------------------------------------------------------------------------------
package ncc_pkg;

  localparam int MAX_CENTROIDS_DEF = 16;
  localparam int MAX_DIMS_DEF      = 8;
  localparam int COORD_BITS_DEF    = 16;

  localparam int FIELD_W          = 16;
  localparam int NUM_COORD_FIELDS = 8;
  localparam int ROW_IDX_W        = 4;
  localparam int LABEL_W          = 4;
  localparam int DIST_W           = 35;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int AC_W       = 5;
  localparam int AD_W       = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic [AC_W-1:0] AC_RESET = 5'd16;
  localparam logic [AD_W-1:0] AD_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CENTROIDS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS      = 4'd1;

  typedef enum logic {
    REQ_WRITE    = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_type_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } ncc_tag_t;

endpackage
`default_nettype wire

### rtl/nearest_centroid_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// nearest_centroid_classifier_top: squared Euclidean nearest centroid search
// A write item loads one centroid row; rows read as zero
// until written. A classify item reads one centroid row per cycle from the
// table port and feeds it to MAX_DIMS lanes that square the coordinate
// differences in parallel; a registered adder tree and a compare stage keep
// the nearest row, lowest index on ties. The table's single read port serves
// the rows in turn. One classify item is in flight at a time. A finished
// result sits in the output register while the next item is accepted.
//------------------------------------------------------------------------------
module nearest_centroid_classifier_top
  import ncc_pkg::*;
#(
  parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
  parameter int MAX_DIMS      = MAX_DIMS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [ROW_IDX_W-1:0]      in_centroid_index,
  input  logic signed [FIELD_W-1:0] in_coord_0,
  input  logic signed [FIELD_W-1:0] in_coord_1,
  input  logic signed [FIELD_W-1:0] in_coord_2,
  input  logic signed [FIELD_W-1:0] in_coord_3,
  input  logic signed [FIELD_W-1:0] in_coord_4,
  input  logic signed [FIELD_W-1:0] in_coord_5,
  input  logic signed [FIELD_W-1:0] in_coord_6,
  input  logic signed [FIELD_W-1:0] in_coord_7,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [LABEL_W-1:0]        out_label,
  output logic [DIST_W-1:0]         out_min_distance,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int RW  = MAX_DIMS * COORD_BITS;
  localparam int CXW = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int SQW = 2 * COORD_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [AC_W-1:0]        active_centroids_r;
  logic [AD_W-1:0]        active_dims_r;
  logic [FIELD_W-1:0]     coord_in [NUM_COORD_FIELDS];
  logic [COORD_BITS-1:0]  pt_in    [MAX_DIMS];
  logic [COORD_BITS-1:0]  point_r  [MAX_DIMS];
  logic [RW-1:0]          wr_row;
  logic [MAX_DIMS-1:0]    dim_mask_nxt;
  logic [MAX_DIMS-1:0]    dim_mask_r;
  logic [IW-1:0]          last_idx_nxt;
  logic [IW-1:0]          last_idx_r;
  logic [IW-1:0]          rd_idx_r;
  logic                   in_acc;
  logic                   wr_en;
  logic                   out_load;
  ncc_tag_t               rd_tag;
  ncc_tag_t               tbl_tag;
  ncc_tag_t               lane_tag_r;
  logic [RW-1:0]          tbl_row;
  logic [SQW-1:0]         lane_sq [MAX_DIMS];
  logic                   mg_done;
  logic [IW-1:0]          mg_idx;
  logic [DIST_W-1:0]      mg_dist;
  logic                   out_valid_r;
  logic [LABEL_W-1:0]     out_label_r;
  logic [DIST_W-1:0]      out_dist_r;

  assign coord_in[0] = in_coord_0;
  assign coord_in[1] = in_coord_1;
  assign coord_in[2] = in_coord_2;
  assign coord_in[3] = in_coord_3;
  assign coord_in[4] = in_coord_4;
  assign coord_in[5] = in_coord_5;
  assign coord_in[6] = in_coord_6;
  assign coord_in[7] = in_coord_7;

  // low COORD_BITS of each field; dimensions without a field load zero
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_pt
    if (d < NUM_COORD_FIELDS) begin : g_fld
      logic [CXW-1:0] fld_ext;
      assign fld_ext  = CXW'(coord_in[d]);
      assign pt_in[d] = fld_ext[COORD_BITS-1:0];
    end else begin : g_zero
      assign pt_in[d] = '0;
    end
    assign wr_row[d*COORD_BITS +: COORD_BITS] = pt_in[d];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_centroids_r <= AC_RESET;
      active_dims_r      <= AD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_CENTROIDS: active_centroids_r <= cfg_data;
        CFG_ACTIVE_DIMS:      active_dims_r      <= cfg_data[AD_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts act as one, large counts saturate
  always_comb begin
    if (active_centroids_r == '0) begin
      last_idx_nxt = '0;
    end else if (int'(active_centroids_r) > MAX_CENTROIDS) begin
      last_idx_nxt = IW'(MAX_CENTROIDS - 1);
    end else begin
      last_idx_nxt = IW'(active_centroids_r - 1'b1);
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (active_dims_r == '0) begin
        dim_mask_nxt[d] = (d == 0);
      end else begin
        dim_mask_nxt[d] = (d < int'(active_dims_r));
      end
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && (in_req_type == REQ_WRITE) &&
                    (int'(in_centroid_index) < MAX_CENTROIDS);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      point_r    <= pt_in;
      dim_mask_r <= dim_mask_nxt;
      last_idx_r <= last_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_req_type == REQ_CLASSIFY)) begin
            rd_idx_r <= '0;
            state_r  <= S_RUN;
          end
        end
        S_RUN: begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r == last_idx_r) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (mg_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_label_r <= LABEL_W'(mg_idx);
            out_dist_r  <= mg_dist;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rd_tag.vld   = (state_r == S_RUN);
  assign rd_tag.first = (rd_idx_r == '0);
  assign rd_tag.last  = (rd_idx_r == last_idx_r);

  ncc_table #(
    .ROWS (MAX_CENTROIDS),
    .DIMS (MAX_DIMS),
    .CB   (COORD_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_idx   (IW'(in_centroid_index)),
    .wr_row   (wr_row),
    .rd_idx   (rd_idx_r),
    .rd_tag   (rd_tag),
    .rd_row   (tbl_row),
    .rd_tag_q (tbl_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_tag_r <= '0;
    end else begin
      lane_tag_r <= tbl_tag;
    end
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    ncc_lane #(
      .CB (COORD_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (dim_mask_r[d]),
      .pt   (point_r[d]),
      .ct   (tbl_row[d*COORD_BITS +: COORD_BITS]),
      .sq_r (lane_sq[d])
    );
  end

  ncc_merge #(
    .ROWS (MAX_CENTROIDS),
    .DIMS (MAX_DIMS),
    .CB   (COORD_BITS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .sq          (lane_sq),
    .tag_in      (lane_tag_r),
    .done_r      (mg_done),
    .best_idx_r  (mg_idx),
    .best_dist_r (mg_dist)
  );

  assign out_valid        = out_valid_r;
  assign out_label        = out_label_r;
  assign out_min_distance = out_dist_r;

endmodule
`default_nettype wire

### rtl/ncc_table.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// ncc_table: centroid row memory
// One row of all coordinates per entry, one write and one registered read per
// cycle. Per-row valid bits make rows never written read as zero.
//------------------------------------------------------------------------------
module ncc_table
  import ncc_pkg::*;
#(
  parameter int ROWS = MAX_CENTROIDS_DEF,
  parameter int DIMS = MAX_DIMS_DEF,
  parameter int CB   = COORD_BITS_DEF,
  localparam int IW  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int RW  = DIMS * CB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic [RW-1:0] wr_row,
  input  logic [IW-1:0] rd_idx,
  input  ncc_tag_t      rd_tag,
  output logic [RW-1:0] rd_row,
  output ncc_tag_t      rd_tag_q
);

  logic [RW-1:0]   mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [RW-1:0]   rd_data_r;
  logic            rd_vld_r;
  ncc_tag_t        tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      tag_r     <= '0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_idx] <= 1'b1;
      end
      tag_r <= rd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    rd_data_r <= mem[rd_idx];
    rd_vld_r  <= row_vld_r[rd_idx];
  end

  assign rd_row   = rd_vld_r ? rd_data_r : '0;
  assign rd_tag_q = tag_r;

endmodule
`default_nettype wire

### rtl/ncc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// ncc_lane: one dimension of the distance datapath
// Signed difference of point and centroid coordinate, squared and registered.
// Inactive dimensions contribute zero.
//------------------------------------------------------------------------------
module ncc_lane
  import ncc_pkg::*;
#(
  parameter int CB   = COORD_BITS_DEF,
  localparam int SQW = 2 * CB + 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CB-1:0] pt,
  input  logic signed [CB-1:0] ct,
  output logic [SQW-1:0]       sq_r
);

  logic signed [CB:0]   diff;
  logic        [CB:0]   mag;
  logic        [2*CB+1:0] prod;
  logic        [SQW-1:0] sq_nxt;

  assign diff   = $signed({pt[CB-1], pt}) - $signed({ct[CB-1], ct});
  assign mag    = diff[CB] ? $unsigned(-diff) : $unsigned(diff);
  assign prod   = mag * mag;
  assign sq_nxt = en ? prod[SQW-1:0] : '0;

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

endmodule
`default_nettype wire

### rtl/ncc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// ncc_merge: lane merge and running minimum
// Registered adder tree over the lane squares, saturation to the distance
// width, then a compare stage that keeps the smallest distance per item.
//------------------------------------------------------------------------------
module ncc_merge
  import ncc_pkg::*;
#(
  parameter int ROWS  = MAX_CENTROIDS_DEF,
  parameter int DIMS  = MAX_DIMS_DEF,
  parameter int CB    = COORD_BITS_DEF,
  localparam int IW   = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int SQW  = 2 * CB + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SQW-1:0]    sq [DIMS],
  input  ncc_tag_t          tag_in,
  output logic              done_r,
  output logic [IW-1:0]     best_idx_r,
  output logic [DIST_W-1:0] best_dist_r
);

  localparam int LVL  = (DIMS > 1) ? $clog2(DIMS) : 0;
  localparam int NP   = 1 << LVL;
  localparam int SUMW = SQW + LVL;
  localparam int EXTW = (SUMW > DIST_W) ? SUMW : DIST_W;

  logic [SUMW-1:0]   tree_r [LVL+1][NP];
  ncc_tag_t          tag_r  [LVL+1];
  logic [EXTW-1:0]   sum_ext;
  logic [DIST_W-1:0] dist_sat;
  logic [IW-1:0]     idx_nxt;
  logic [IW-1:0]     cur_idx_r;
  ncc_tag_t          tag_q;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NP; i++) begin
      if (i < DIMS) begin
        tree_r[0][i] <= SUMW'(sq[i]);
      end else begin
        tree_r[0][i] <= '0;
      end
    end
    for (int l = 1; l <= LVL; l++) begin
      for (int i = 0; i < NP; i++) begin
        if (i < (NP >> l)) begin
          tree_r[l][i] <= tree_r[l-1][2*i] + tree_r[l-1][2*i+1];
        end else begin
          tree_r[l][i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l <= LVL; l++) begin
        tag_r[l] <= '0;
      end
    end else begin
      tag_r[0] <= tag_in;
      for (int l = 1; l <= LVL; l++) begin
        tag_r[l] <= tag_r[l-1];
      end
    end
  end

  assign tag_q    = tag_r[LVL];
  assign sum_ext  = EXTW'(tree_r[LVL][0]);
  assign dist_sat = (sum_ext > EXTW'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_W-1:0];
  assign idx_nxt  = tag_q.first ? '0 : cur_idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= tag_q.vld && tag_q.last;
    end
  end

  // ties keep the lower index
  always_ff @(posedge clk) begin
    if (tag_q.vld) begin
      cur_idx_r <= idx_nxt;
      if (tag_q.first || (dist_sat < best_dist_r)) begin
        best_dist_r <= dist_sat;
        best_idx_r  <= idx_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ncc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// ncc_checker: port-level assertions for the classifier top
// Watches the item channels only; bound to the top level below.
//------------------------------------------------------------------------------
module ncc_checker
  import ncc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_req_type,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [LABEL_W-1:0]        out_label,
  input logic [DIST_W-1:0]         out_min_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_label) && $stable(out_min_distance))
    else $error("result item changed while stalled");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_CLASSIFY) |=> !in_ready)
    else $error("input taken during a classify search");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_WRITE) && !out_valid |=> !out_valid)
    else $error("row write produced a result item");

  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result item appeared without a search in flight");

endmodule

bind nearest_centroid_classifier_top ncc_checker u_ncc_checker (.*);
`default_nettype wire
